### hw/rtl/resonator_filter_bank_unit_macros.svh
// ----------------------------------------------------------------------------
// Resonator filter bank assertion macros
// Assertion helpers shared by the resonator filter bank RTL. They compile
// to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RESONATOR_FILTER_BANK_UNIT_MACROS_SVH
`define RESONATOR_FILTER_BANK_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising edge outside reset.
`define RFB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be true at a rising edge outside reset.
`define RFB_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define RFB_ASSERT(label, clk, rst_n, prop, msg)
`define RFB_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

### hw/rtl/rfb_pkg.sv
// ----------------------------------------------------------------------------
// Resonator filter bank package
// Field widths, command codes and the controller to datapath interface.
// ----------------------------------------------------------------------------
package rfb_pkg;

  localparam int COEF_W   = 24;
  localparam int HIST_W   = 32;
  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 4;
  localparam int ACTIVE_W = 5;
  localparam int PROD_W   = COEF_W + HIST_W;
  // Three exact products plus the rounding offset fit in 58 signed bits.
  localparam int ACC_W    = PROD_W + 2;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

  localparam logic [HIST_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
  localparam logic [HIST_W-1:0] VALUE_MIN = 32'h8000_0000;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_PROCESS = 1'b1;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [1:0] {
    MUL_GAIN = 2'd0,
    MUL_FB1  = 2'd1,
    MUL_FB2  = 2'd2
  } rfb_mul_e;

  typedef struct packed {
    logic     load_we;
    logic     capture;
    logic     rd_en;
    logic     mul_en;
    rfb_mul_e mul_sel;
    logic     acc_init;
    logic     acc_add;
    logic     out_load;
    logic     last;
    logic     clear_hist;
  } rfb_cmd_t;

  typedef struct packed {
    logic out_free;
  } rfb_status_t;

endpackage

### hw/rtl/rfb_ctrl.sv
// ----------------------------------------------------------------------------
// Resonator filter bank controller
// Holds the active filter count and sequences the datapath through one
// read, three multiply passes, a final add and one output step per active filter.
// ----------------------------------------------------------------------------
module rfb_ctrl #(
  parameter int FILTER_COUNT = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic                          end_of_signal_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rfb_pkg::ACTIVE_W-1:0]  cfg_data_i,
  input  rfb_pkg::rfb_status_t          status_i,
  output rfb_pkg::rfb_cmd_t             cmd_o,
  output logic [((FILTER_COUNT > 1) ? $clog2(FILTER_COUNT) : 1)-1:0] idx_o
);

  localparam int IdxW = (FILTER_COUNT > 1) ? $clog2(FILTER_COUNT) : 1;
  localparam int CntW = $clog2(FILTER_COUNT + 1);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_READ = 7'b0000010,
    ST_MUL0 = 7'b0000100,
    ST_MUL1 = 7'b0001000,
    ST_MUL2 = 7'b0010000,
    ST_ACC  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_e;

  state_e                        state_q, state_d;
  logic [IdxW-1:0]               f_q, f_d;
  logic                          eos_q, eos_d;
  logic [rfb_pkg::ACTIVE_W-1:0]  active_q;
  logic [CntW-1:0]               n_act;
  logic                          accept;
  logic                          is_last;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign idx_o       = f_q;

  // Counts above the bank size act as the bank size.
  assign n_act   = (32'(active_q) > FILTER_COUNT) ? CntW'(FILTER_COUNT) : CntW'(active_q);
  assign is_last = ((CntW'(f_q) + CntW'(1)) == n_act);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= rfb_pkg::ACTIVE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      active_q <= cfg_data_i;
    end
  end

  always_comb begin
    state_d = state_q;
    f_d     = f_q;
    eos_d   = eos_q;
    cmd_o   = '0;
    cmd_o.mul_sel = rfb_pkg::MUL_GAIN;
    case (state_q)
      ST_IDLE: begin
        if (accept && (command_i == rfb_pkg::CMD_LOAD)) begin
          cmd_o.load_we = 1'b1;
        end else if (accept) begin
          if (n_act == '0) begin
            cmd_o.clear_hist = end_of_signal_i;
          end else begin
            cmd_o.capture = 1'b1;
            eos_d         = end_of_signal_i;
            f_d           = '0;
            state_d       = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_MUL0;
      end
      ST_MUL0: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = rfb_pkg::MUL_GAIN;
        cmd_o.acc_init = 1'b1;
        state_d        = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rfb_pkg::MUL_FB1;
        cmd_o.acc_add = 1'b1;
        state_d       = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rfb_pkg::MUL_FB2;
        cmd_o.acc_add = 1'b1;
        state_d       = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_add = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        // Wait here until the output register can take the word.
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.last     = is_last;
          if (is_last) begin
            cmd_o.clear_hist = eos_q;
            state_d          = ST_IDLE;
          end else begin
            f_d     = f_q + IdxW'(1);
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      f_q     <= '0;
      eos_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      f_q     <= f_d;
      eos_q   <= eos_d;
    end
  end

endmodule

### hw/rtl/rfb_dpath.sv
// ----------------------------------------------------------------------------
// Resonator filter bank datapath
// Coefficient and history memories, one shared multiplier, the accumulator
// with rounding and saturation, and the output register.
// ----------------------------------------------------------------------------
module rfb_dpath #(
  parameter int FILTER_COUNT       = 16,
  parameter int COEF_FRACTION_BITS = 22
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rfb_pkg::rfb_cmd_t                   cmd_i,
  input  logic [((FILTER_COUNT > 1) ? $clog2(FILTER_COUNT) : 1)-1:0] idx_i,
  input  logic [rfb_pkg::INDEX_W-1:0]         filter_index_i,
  input  logic signed [rfb_pkg::COEF_W-1:0]   coef_b0_i,
  input  logic signed [rfb_pkg::COEF_W-1:0]   coef_a1_i,
  input  logic signed [rfb_pkg::COEF_W-1:0]   coef_a2_i,
  input  logic signed [rfb_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                out_ready_i,
  output rfb_pkg::rfb_status_t                status_o,
  output logic                                out_valid_o,
  output logic [rfb_pkg::INDEX_W-1:0]         channel_o,
  output logic signed [rfb_pkg::HIST_W-1:0]   value_o,
  output logic                                saturated_o,
  output logic                                last_o
);

  localparam int IdxW   = (FILTER_COUNT > 1) ? $clog2(FILTER_COUNT) : 1;
  localparam int CW     = rfb_pkg::COEF_W;
  localparam int HW     = rfb_pkg::HIST_W;
  localparam int PW     = rfb_pkg::PROD_W;
  localparam int AW     = rfb_pkg::ACC_W;
  localparam logic signed [AW-1:0] RoundInit = AW'(64'd1 << (COEF_FRACTION_BITS - 1));

  // Coefficient memories and the packed {y1, y2} history memory.
  logic [CW-1:0]   b0_mem [FILTER_COUNT];
  logic [CW-1:0]   a1_mem [FILTER_COUNT];
  logic [CW-1:0]   a2_mem [FILTER_COUNT];
  logic [2*HW-1:0] hist_mem [FILTER_COUNT];

  logic signed [CW-1:0]       b0_rd_q, a1_rd_q, a2_rd_q;
  logic [2*HW-1:0]            hist_rd_q;
  logic                       hv_q;
  logic [FILTER_COUNT-1:0]    hist_vld_q;
  logic signed [rfb_pkg::SAMPLE_W-1:0] sample_q;

  logic                       load_ok;
  logic [IdxW-1:0]            wr_idx;
  logic signed [HW-1:0]       y1_cur, y2_cur;
  logic signed [CW-1:0]       mul_coef;
  logic signed [HW-1:0]       mul_data;
  logic signed [PW-1:0]       prod;
  logic signed [PW-1:0]       p_q;
  logic signed [AW-1:0]       acc_q;
  logic signed [AW-1:0]       acc_shr;
  logic                       fits;
  logic [HW-1:0]              y_sat;

  logic                       out_valid_q;
  logic [rfb_pkg::INDEX_W-1:0] channel_q;
  logic [HW-1:0]              value_q;
  logic                       sat_q;
  logic                       last_q;

  // Loads beyond the bank are dropped.
  assign load_ok = cmd_i.load_we && (32'(filter_index_i) < FILTER_COUNT);
  assign wr_idx  = IdxW'(filter_index_i);

  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      b0_mem[wr_idx] <= coef_b0_i;
      a1_mem[wr_idx] <= coef_a1_i;
      a2_mem[wr_idx] <= coef_a2_i;
    end
    if (cmd_i.rd_en) begin
      b0_rd_q <= b0_mem[idx_i];
      a1_rd_q <= a1_mem[idx_i];
      a2_rd_q <= a2_mem[idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      hist_mem[idx_i] <= {y_sat, y1_cur};
    end
    if (cmd_i.rd_en) begin
      hist_rd_q <= hist_mem[idx_i];
    end
    if (cmd_i.capture) begin
      sample_q <= sample_i;
    end
  end

  // A history entry without its valid bit reads as zero; end of signal
  // drops every valid bit at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
      hv_q       <= 1'b0;
    end else begin
      if (cmd_i.clear_hist) begin
        hist_vld_q <= '0;
      end else if (cmd_i.out_load) begin
        hist_vld_q[idx_i] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        hv_q <= hist_vld_q[idx_i];
      end
    end
  end

  assign y1_cur = hv_q ? hist_rd_q[2*HW-1:HW] : '0;
  assign y2_cur = hv_q ? hist_rd_q[HW-1:0] : '0;

  always_comb begin
    case (cmd_i.mul_sel)
      rfb_pkg::MUL_GAIN: begin
        mul_coef = b0_rd_q;
        mul_data = HW'(sample_q);
      end
      rfb_pkg::MUL_FB1: begin
        mul_coef = a1_rd_q;
        mul_data = y1_cur;
      end
      rfb_pkg::MUL_FB2: begin
        mul_coef = a2_rd_q;
        mul_data = y2_cur;
      end
      default: begin
        mul_coef = '0;
        mul_data = '0;
      end
    endcase
  end

  assign prod = mul_coef * mul_data;

  // The accumulator starts at half an output unit so that the final
  // arithmetic shift rounds half up.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      p_q <= prod;
    end
    if (cmd_i.acc_init) begin
      acc_q <= RoundInit;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + AW'(p_q);
    end
  end

  assign acc_shr = acc_q >>> COEF_FRACTION_BITS;
  assign fits    = (&acc_shr[AW-1:HW-1]) || !(|acc_shr[AW-1:HW-1]);
  assign y_sat   = fits ? acc_shr[HW-1:0] :
                   (acc_shr[AW-1] ? rfb_pkg::VALUE_MIN : rfb_pkg::VALUE_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      channel_q <= rfb_pkg::INDEX_W'(idx_i);
      value_q   <= y_sat;
      sat_q     <= !fits;
      last_q    <= cmd_i.last;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign channel_o         = channel_q;
  assign value_o           = value_q;
  assign saturated_o       = sat_q;
  assign last_o            = last_q;

endmodule

### hw/rtl/resonator_filter_bank_unit.sv
// ----------------------------------------------------------------------------
// Resonator filter bank unit
// A bank of FILTER_COUNT two-pole resonators sharing one multiplier. A load
// word is written when it is accepted, and the unit stays ready for the next
// word. For a sample word, each active filter needs a memory read, three
// passes through the single 24x32 multiplier, a final add, and a step into
// the output register, which also stalls while a word waits there. Output
// histories carry one valid bit per filter, so reset and end of signal clear
// them at once with no clearing pass. The next word is accepted as soon as
// the last result of a sample enters the output register.
// ----------------------------------------------------------------------------
`include "resonator_filter_bank_unit_macros.svh"

module resonator_filter_bank_unit #(
  parameter int FILTER_COUNT       = 16,
  parameter int COEF_FRACTION_BITS = 22
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                command_i,
  input  logic [rfb_pkg::INDEX_W-1:0]         filter_index_i,
  input  logic signed [rfb_pkg::COEF_W-1:0]   coef_b0_i,
  input  logic signed [rfb_pkg::COEF_W-1:0]   coef_a1_i,
  input  logic signed [rfb_pkg::COEF_W-1:0]   coef_a2_i,
  input  logic signed [rfb_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                end_of_signal_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rfb_pkg::INDEX_W-1:0]         channel_o,
  output logic signed [rfb_pkg::HIST_W-1:0]   value_o,
  output logic                                saturated_o,
  output logic                                last_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rfb_pkg::ACTIVE_W-1:0]        cfg_data_i
);

  localparam int IdxW = (FILTER_COUNT > 1) ? $clog2(FILTER_COUNT) : 1;

  rfb_pkg::rfb_cmd_t    cmd;
  rfb_pkg::rfb_status_t dp_status;
  logic [IdxW-1:0]      idx;

  rfb_ctrl #(
    .FILTER_COUNT (FILTER_COUNT)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .end_of_signal_i (end_of_signal_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .status_i        (dp_status),
    .cmd_o           (cmd),
    .idx_o           (idx)
  );

  rfb_dpath #(
    .FILTER_COUNT       (FILTER_COUNT),
    .COEF_FRACTION_BITS (COEF_FRACTION_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .idx_i          (idx),
    .filter_index_i (filter_index_i),
    .coef_b0_i      (coef_b0_i),
    .coef_a1_i      (coef_a1_i),
    .coef_a2_i      (coef_a2_i),
    .sample_i       (sample_i),
    .out_ready_i    (out_ready_i),
    .status_o       (dp_status),
    .out_valid_o    (out_valid_o),
    .channel_o      (channel_o),
    .value_o        (value_o),
    .saturated_o    (saturated_o),
    .last_o         (last_o)
  );

  // A new word must never overwrite one that has not been taken.
  `RFB_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd.out_load && !dp_status.out_free, "output word overwritten before it was taken")
  // A history read is always followed by the gain multiply pass.
  `RFB_ASSERT(a_read_then_gain, clk_i, rst_ni, cmd.rd_en |=> cmd.mul_en && (cmd.mul_sel == rfb_pkg::MUL_GAIN), "multiply sequence broken after read")
  // A clipped word carries one of the two range limits.
  `RFB_ASSERT(a_sat_value, clk_i, rst_ni, (out_valid_o && saturated_o) |-> (value_o == rfb_pkg::VALUE_MAX) || (value_o == rfb_pkg::VALUE_MIN), "saturated word not at a range limit")

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// Resonator filter bank unit testbench
// Writes the filter count register, loads coefficient sets and streams samples
// through the bank under random sender gaps and receiver stalls. A scoreboard
// class keeps its own coefficient tables and output histories, predicts every
// filter output of each accepted sample word and compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import rfb_pkg::*;

  localparam int FILTERS      = 16;
  localparam int FRAC_BITS    = 22;
  localparam int SETTLE_TICKS = 128;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_WORDS  = 50;

  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0] UNITY    = COEF_W'(1 << FRAC_BITS);
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_e;

  typedef struct {
    logic                       command;
    logic [INDEX_W-1:0]         filter_index;
    logic signed [COEF_W-1:0]   b0;
    logic signed [COEF_W-1:0]   a1;
    logic signed [COEF_W-1:0]   a2;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       eos;
  } bank_word_t;

  typedef struct {
    logic [INDEX_W-1:0]       channel;
    logic signed [HIST_W-1:0] value;
    logic                     saturated;
    logic                     last;
  } bank_output_t;

  class resonator_bank_model;
    logic [ACTIVE_W-1:0]      active_filters;
    logic signed [COEF_W-1:0] gain[FILTERS];
    logic signed [COEF_W-1:0] fb_one[FILTERS];
    logic signed [COEF_W-1:0] fb_two[FILTERS];
    logic signed [HIST_W-1:0] y_prev[FILTERS];
    logic signed [HIST_W-1:0] y_prev2[FILTERS];
    bank_output_t             expected_outputs[$];
    int unsigned              mismatches;
    int unsigned              outputs_checked;
    int unsigned              clipped_outputs;
    int unsigned              loads_taken;
    int unsigned              samples_taken;

    function new();
      active_filters  = ACTIVE_RESET;
      mismatches      = 0;
      outputs_checked = 0;
      clipped_outputs = 0;
      loads_taken     = 0;
      samples_taken   = 0;
      clear_history();
    endfunction

    function void clear_history();
      for (int f = 0; f < FILTERS; f++) begin
        y_prev[f]  = '0;
        y_prev2[f] = '0;
      end
    endfunction

    // Updates the tables on a load, or queues one output per active filter.
    function void predict_word(bank_word_t w);
      int           count;
      longint       acc;
      longint       y;
      bank_output_t o;
      if (w.command == CMD_LOAD) begin
        gain[w.filter_index]   = w.b0;
        fb_one[w.filter_index] = w.a1;
        fb_two[w.filter_index] = w.a2;
        loads_taken++;
        return;
      end
      samples_taken++;
      count = (active_filters > FILTERS) ? FILTERS : int'(active_filters);
      for (int f = 0; f < count; f++) begin
        acc = longint'(gain[f]) * longint'(w.sample)
            + longint'(fb_one[f]) * longint'(y_prev[f])
            + longint'(fb_two[f]) * longint'(y_prev2[f]);
        // Round half up, then floor through the arithmetic shift.
        y = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        o.saturated = 1'b0;
        if (y > longint'($signed(VALUE_MAX))) begin
          y = longint'($signed(VALUE_MAX));
          o.saturated = 1'b1;
        end else if (y < longint'($signed(VALUE_MIN))) begin
          y = longint'($signed(VALUE_MIN));
          o.saturated = 1'b1;
        end
        y_prev2[f]  = y_prev[f];
        y_prev[f]   = HIST_W'(y);
        o.channel   = f[INDEX_W-1:0];
        o.value     = HIST_W'(y);
        o.last      = (f == count - 1);
        expected_outputs.push_back(o);
      end
      if (w.eos) clear_history();
    endfunction

    function void check_output(bank_output_t got);
      bank_output_t want;
      if (expected_outputs.size() == 0) begin
        $error("output on channel %0d arrived with nothing expected", got.channel);
        mismatches++;
        return;
      end
      want = expected_outputs.pop_front();
      outputs_checked++;
      if (got.saturated) clipped_outputs++;
      if (got.channel !== want.channel) begin
        $error("channel mismatch: expected %0d, actual %0d", want.channel, got.channel);
        mismatches++;
      end
      if (got.value !== want.value) begin
        $error("value mismatch: expected %0d, actual %0d", want.value, got.value);
        mismatches++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated mismatch: expected %0d, actual %0d", want.saturated, got.saturated);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last mismatch: expected %0d, actual %0d", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni        = 1'b0;
  logic                       in_valid      = 1'b0;
  logic                       command       = CMD_LOAD;
  logic [INDEX_W-1:0]         filter_index  = '0;
  logic signed [COEF_W-1:0]   coef_b0       = '0;
  logic signed [COEF_W-1:0]   coef_a1       = '0;
  logic signed [COEF_W-1:0]   coef_a2       = '0;
  logic signed [SAMPLE_W-1:0] sample        = '0;
  logic                       end_of_signal = 1'b0;
  logic                       out_ready     = 1'b0;
  logic                       cfg_valid     = 1'b0;
  logic [ACTIVE_W-1:0]        cfg_data      = '0;
  logic                       in_ready_o;
  logic                       out_valid_o;
  logic [INDEX_W-1:0]         channel_o;
  logic signed [HIST_W-1:0]   value_o;
  logic                       saturated_o;
  logic                       last_o;
  logic                       cfg_ready_o;

  resonator_bank_model bank;
  bank_output_t        observed;
  rx_mode_e            rx_mode  = RX_OPEN;
  int unsigned         rx_count = 0;
  int unsigned         rx_tick  = 0;
  int unsigned         settings_used = 0;

  resonator_filter_bank_unit #(
    .FILTER_COUNT      (FILTERS),
    .COEF_FRACTION_BITS(FRAC_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .command_i      (command),
    .filter_index_i (filter_index),
    .coef_b0_i      (coef_b0),
    .coef_a1_i      (coef_a1),
    .coef_a2_i      (coef_a2),
    .sample_i       (sample),
    .end_of_signal_i(end_of_signal),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .channel_o      (channel_o),
    .value_o        (value_o),
    .saturated_o    (saturated_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // The receiver switches between randomly chosen stall patterns.
  always @(negedge clk_i) begin
    if (rx_count == 0) begin
      rx_mode  = rx_mode_e'($urandom_range(0, 3));
      rx_count = $urandom_range(20, 200);
    end
    rx_count--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:     out_ready <= 1'b1;
      RX_COIN:     out_ready <= ($urandom_range(0, 1) == 1);
      RX_PERIODIC: out_ready <= ((rx_tick % 5) < 2);
      default:     out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      observed.channel   = channel_o;
      observed.value     = value_o;
      observed.saturated = saturated_o;
      observed.last      = last_o;
      bank.check_output(observed);
    end
  end

  function automatic bank_word_t make_word(logic cmd, logic [INDEX_W-1:0] idx,
                                           logic signed [COEF_W-1:0] b0,
                                           logic signed [COEF_W-1:0] a1,
                                           logic signed [COEF_W-1:0] a2,
                                           logic signed [SAMPLE_W-1:0] smp, logic eos);
    bank_word_t w;
    w.command      = cmd;
    w.filter_index = idx;
    w.b0           = b0;
    w.a1           = a1;
    w.a2           = a2;
    w.sample       = smp;
    w.eos          = eos;
    return w;
  endfunction

  // Mixes extremes, gentle values that keep a filter stable, and full-range noise.
  function automatic logic signed [COEF_W-1:0] pick_coef();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 5))
      0:       return COEF_MAX;
      1:       return COEF_MIN;
      2:       return {{2{r[21]}}, r[21:0]};
      default: return r[COEF_W-1:0];
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return {{8{r[7]}}, r[7:0]};
      default: return r[SAMPLE_W-1:0];
    endcase
  endfunction

  function automatic bank_word_t random_word();
    logic [31:0] r;
    r = $urandom;
    return make_word(($urandom_range(0, 4) == 0) ? CMD_LOAD : CMD_PROCESS,
                     r[INDEX_W-1:0], pick_coef(), pick_coef(), pick_coef(),
                     pick_sample(), ($urandom_range(0, 24) == 0));
  endfunction

  // Entered just after a falling edge and returns just after one, so a
  // following word keeps valid high with no gap between the two words.
  task automatic push_word(input bank_word_t w);
    in_valid      <= 1'b1;
    command       <= w.command;
    filter_index  <= w.filter_index;
    coef_b0       <= w.b0;
    coef_a1       <= w.a1;
    coef_a2       <= w.a2;
    sample        <= w.sample;
    end_of_signal <= w.eos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bank.predict_word(w);
    @(negedge clk_i);
  endtask

  task automatic idle_for(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Loads and empty samples give no output, so the bank may still be busy
  // when the queue runs dry; the extra cycles cover one full sample word.
  task automatic settle_bank();
    in_valid <= 1'b0;
    while (bank.expected_outputs.size() != 0) @(negedge clk_i);
    repeat (SETTLE_TICKS) @(negedge clk_i);
  endtask

  task automatic write_active(input logic [ACTIVE_W-1:0] setting);
    cfg_valid <= 1'b1;
    cfg_data  <= setting;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    bank.active_filters = setting;
    settings_used++;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [ACTIVE_W-1:0] setting, input int count);
    int burst_left;
    int hold_at;
    burst_left = 0;
    hold_at    = $urandom_range(5, count - 5);
    settle_bank();
    write_active(setting);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) begin
        settle_bank();
      end else if (burst_left == 0) begin
        idle_for(($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                             : $urandom_range(1, 12));
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 6);
      end
      push_word(random_word());
      if (burst_left > 0) burst_left--;
    end
  endtask

  initial begin
    logic [ACTIVE_W-1:0] setting;
    bank = new();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_active(ACTIVE_W'(FILTERS));

    // Every filter gets coefficients before the first sample reads them.
    push_word(make_word(CMD_LOAD, INDEX_W'(0), COEF_MAX, COEF_MAX, COEF_MIN, SAMPLE_MAX,
                        1'b0));
    push_word(make_word(CMD_LOAD, INDEX_W'(1), COEF_MIN, COEF_MIN, COEF_MAX, SAMPLE_MIN,
                        1'b0));
    // An end-of-signal flag on a load word must not clear anything.
    push_word(make_word(CMD_LOAD, INDEX_W'(2), UNITY, '0, '0, '0, 1'b1));
    for (int k = 3; k < FILTERS; k++) begin
      push_word(make_word(CMD_LOAD, k[INDEX_W-1:0], pick_coef(), pick_coef(), pick_coef(),
                          pick_sample(), 1'b0));
    end
    push_word(make_word(CMD_PROCESS, 4'hF, COEF_MIN, COEF_MAX, COEF_MIN, SAMPLE_MAX, 1'b0));
    push_word(make_word(CMD_PROCESS, 4'h0, '0, '0, '0, SAMPLE_MIN, 1'b0));
    push_word(make_word(CMD_PROCESS, 4'h5, '0, '0, '0, '0, 1'b0));
    push_word(make_word(CMD_PROCESS, 4'hA, '0, '0, '0, SAMPLE_MAX, 1'b1));
    push_word(make_word(CMD_PROCESS, 4'h3, '0, '0, '0, SAMPLE_MIN, 1'b0));

    settle_bank();
    write_active(ACTIVE_W'(1));
    push_word(make_word(CMD_PROCESS, 4'h0, '0, '0, '0, 16'sd12345, 1'b0));
    push_word(make_word(CMD_PROCESS, 4'h0, '0, '0, '0, -16'sd1, 1'b1));

    // With no active filter a sample gives nothing but still clears history.
    settle_bank();
    write_active(ACTIVE_W'(0));
    push_word(make_word(CMD_PROCESS, 4'h0, '0, '0, '0, 16'sd100, 1'b1));
    push_word(make_word(CMD_PROCESS, 4'h0, '0, '0, '0, -16'sd100, 1'b0));

    // A count above the bank size runs every filter.
    settle_bank();
    write_active(5'd31);
    push_word(make_word(CMD_PROCESS, 4'h0, '0, '0, '0, SAMPLE_MAX, 1'b0));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       setting = ACTIVE_W'(FILTERS);
        1:       setting = ACTIVE_W'(1);
        3:       setting = ACTIVE_W'($urandom_range(FILTERS + 1, 31));
        default: setting = ACTIVE_W'($urandom_range(1, FILTERS));
      endcase
      run_phase(setting, PHASE_WORDS);
    end

    settle_bank();
    $display("Ran %0d coefficient loads and %0d samples across %0d filter-count writes.",
             bank.loads_taken, bank.samples_taken, settings_used);
    $display("Compared %0d filter outputs, %0d of them clipped.",
             bank.outputs_checked, bank.clipped_outputs);
    if (bank.mismatches == 0 && bank.expected_outputs.size() == 0) begin
      $display("resonator_filter_bank_unit verification clean");
    end else begin
      $display("resonator_filter_bank_unit verification failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("resonator_filter_bank_unit verification failed");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/rfb_pkg.sv
hw/rtl/rfb_ctrl.sv
hw/rtl/rfb_dpath.sv
hw/rtl/resonator_filter_bank_unit.sv
bench/tb_top.sv
